FILE: hdl/ssrg_pkg.sv
// ----------------------------------------------------------------------------
// ssrg_pkg
// Shared types, constants and lookup functions of the sine speed ramp
// generator: controller states, datapath commands, status and sine constants.
// ----------------------------------------------------------------------------
package ssrg_pkg;

  localparam int STEP_BITS_DEF = 24;
  localparam int SINE_BITS_DEF = 16;

  // 0.001 in Q16.16, rounded to nearest
  localparam logic signed [32:0] EPS_Q16 = 33'sd66;
  // pi in Q2.30 and 1.0 in Q2.30
  localparam logic [31:0] PI_Q30  = 32'd3373259426;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  // reset value of the ramp rate register (100.0)
  localparam logic [31:0] K_RESET = 32'd6553600;
  localparam int NUM_TERMS = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_KMUL,
    ST_STEPS,
    ST_DIV,
    ST_PIMUL,
    ST_AXCAP,
    ST_X2CAP,
    ST_TMUL,
    ST_TREC,
    ST_TCOR,
    ST_SIN,
    ST_OUTP,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MUL_K,
    MUL_PI,
    MUL_AXSQ,
    MUL_TX,
    MUL_REC,
    MUL_W
  } mul_sel_t;

  typedef struct packed {
    logic     load_cmd;
    logic     start_ramp;
    logic     jump;
    logic     settle;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     set_steps;
    logic     div_init;
    logic     div_step;
    logic     ax_cap;
    logic     sin_init;
    logic     v_cap;
    logic     term_upd;
    logic     ramp_out;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic new_ramp;
    logic tiny;
    logic active;
    logic steps_done;
    logic div_last;
    logic term_last;
  } dp_stat_t;

  // Taylor term divisor (2i+2)(2i+3) for term index i = 0..5
  function automatic logic [7:0] term_div(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'd6;
      3'd1:    c = 8'd20;
      3'd2:    c = 8'd42;
      3'd3:    c = 8'd72;
      3'd4:    c = 8'd110;
      default: c = 8'd156;
    endcase
    return c;
  endfunction

  localparam logic [31:0] RECIP_0 = 32'((64'd1 << 32) / 64'd6);
  localparam logic [31:0] RECIP_1 = 32'((64'd1 << 32) / 64'd20);
  localparam logic [31:0] RECIP_2 = 32'((64'd1 << 32) / 64'd42);
  localparam logic [31:0] RECIP_3 = 32'((64'd1 << 32) / 64'd72);
  localparam logic [31:0] RECIP_4 = 32'((64'd1 << 32) / 64'd110);
  localparam logic [31:0] RECIP_5 = 32'((64'd1 << 32) / 64'd156);

  // floor(2^32 / divisor), quotient estimate is low by at most one
  function automatic logic [31:0] term_recip(input logic [2:0] idx);
    logic [31:0] m;
    unique case (idx)
      3'd0:    m = RECIP_0;
      3'd1:    m = RECIP_1;
      3'd2:    m = RECIP_2;
      3'd3:    m = RECIP_3;
      3'd4:    m = RECIP_4;
      default: m = RECIP_5;
    endcase
    return m;
  endfunction

endpackage

FILE: hdl/sine_speed_ramp_generator.sv
// ----------------------------------------------------------------------------
// sine_speed_ramp_generator
// Shapes a commanded speed into a half-sine S-curve ramp, one output point
// per input tick, with an APB-style port for the ramp rate register.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    in_command_speed (Q16.16)
// out_      output     out_valid / out_ready  out_speed (Q16.16), out_ramp_active
// cfg_      input      APB psel/penable       ramp rate at byte address 0
//
// A tick that is settled, jumps or finishes a ramp goes straight to the output;
// a ramp step runs the phase divider and then six sine terms on one shared
// multiplier, and the first step of a new ramp also works out the step count.
// One tick is in flight at a time; a finished result waits in
// the output register while the next tick is taken.
// Reset is synchronous; out_ready low holds the result and stalls the tick.
// ----------------------------------------------------------------------------
module sine_speed_ramp_generator #(
  parameter int STEP_BITS = ssrg_pkg::STEP_BITS_DEF,
  parameter int SINE_BITS = ssrg_pkg::SINE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_command_speed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_speed,
  output logic               out_ramp_active,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import ssrg_pkg::*;

  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  logic [31:0] k_r;

  // ramp rate register
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      k_r <= cfg_pwdata;
    end
  end
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : k_r;

  ssrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssrg_dp #(
    .STEP_BITS (STEP_BITS),
    .SINE_BITS (SINE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .command_speed (in_command_speed),
    .ramp_rate     (k_r),
    .res_speed     (out_speed),
    .res_active    (out_ramp_active)
  );

endmodule

FILE: hdl/ssrg_ctrl.sv
// ----------------------------------------------------------------------------
// ssrg_ctrl
// Sequencer of the ramp generator: walks each tick through the ramp decision,
// then as needed step count, phase division, sine series and output scaling.
// ----------------------------------------------------------------------------
module ssrg_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ssrg_pkg::dp_stat_t    stat,
  output ssrg_pkg::ctrl_cmd_t   cmd
);
  import ssrg_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state and result flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.mul_sel   = MUL_K;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_cmd = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (stat.new_ramp && stat.tiny) begin
          cmd.start_ramp = 1'b1;
          cmd.jump       = 1'b1;
          state_nxt      = ST_DONE;
        end else if (stat.new_ramp) begin
          cmd.start_ramp = 1'b1;
          state_nxt      = ST_KMUL;
        end else if (stat.active && stat.steps_done) begin
          cmd.settle = 1'b1;
          state_nxt  = ST_DONE;
        end else if (stat.active) begin
          cmd.div_init = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_KMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_K;
        state_nxt   = ST_STEPS;
      end
      ST_STEPS: begin
        cmd.set_steps = 1'b1;
        cmd.div_init  = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = ST_PIMUL;
        end
      end
      ST_PIMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_PI;
        state_nxt   = ST_AXCAP;
      end
      ST_AXCAP: begin
        cmd.ax_cap  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_AXSQ;
        state_nxt   = ST_X2CAP;
      end
      ST_X2CAP: begin
        cmd.sin_init = 1'b1;
        state_nxt    = ST_TMUL;
      end
      ST_TMUL: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_TX;
        state_nxt   = ST_TREC;
      end
      ST_TREC: begin
        cmd.v_cap   = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_REC;
        state_nxt   = ST_TCOR;
      end
      ST_TCOR: begin
        cmd.term_upd = 1'b1;
        state_nxt    = stat.term_last ? ST_SIN : ST_TMUL;
      end
      ST_SIN: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_W;
        state_nxt   = ST_OUTP;
      end
      ST_OUTP: begin
        cmd.ramp_out = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/ssrg_dp.sv
// ----------------------------------------------------------------------------
// ssrg_dp
// Datapath of the ramp generator: ramp state, one shared 33x33 multiplier,
// a radix-2 phase divider and the sine series accumulator.
// ----------------------------------------------------------------------------
module ssrg_dp #(
  parameter int STEP_BITS = ssrg_pkg::STEP_BITS_DEF,
  parameter int SINE_BITS = ssrg_pkg::SINE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ssrg_pkg::ctrl_cmd_t   cmd,
  output ssrg_pkg::dp_stat_t    stat,
  input  logic signed [31:0]    command_speed,
  input  logic [31:0]           ramp_rate,
  output logic signed [31:0]    res_speed,
  output logic                  res_active
);
  import ssrg_pkg::*;

  localparam int CNT_W = $clog2(SINE_BITS + 1);
  localparam logic [SINE_BITS:0]   FULL  = (SINE_BITS + 1)'(1) << SINE_BITS;
  localparam logic [SINE_BITS:0]   HALF  = (SINE_BITS + 1)'(1) << (SINE_BITS - 1);
  localparam logic [CNT_W-1:0]     DLAST = CNT_W'(SINE_BITS);
  localparam logic [33:0]          LIMIT = 34'((64'd1 << STEP_BITS) - 64'd1);
  localparam logic [30:0]          RND   = 31'(1) << (29 - SINE_BITS);

  logic signed [31:0] cmd_r, target_r, start_r, output_r;
  logic signed [32:0] span_r;
  logic [STEP_BITS-1:0] total_r, step_r;
  logic active_r;
  logic [STEP_BITS:0] rem_r;
  logic [SINE_BITS:0] q_r;
  logic [CNT_W-1:0] dcnt_r;
  logic [65:0] prod_r;
  logic [31:0] ax_r, x2_r, t_r, v_r;
  logic signed [33:0] s_r;
  logic [2:0] idx_r;

  logic signed [32:0] diff, span_new;
  logic [32:0] mag;
  logic [STEP_BITS-1:0] den;
  logic rem_ge;
  logic u_neg;
  logic [SINE_BITS:0] au;
  logic [32:0] op_a, op_b;
  logic [65:0] prod_nxt;
  logic [31:0] qe, tq;
  logic [7:0] tdiv;
  logic [39:0] qc, rmd;
  logic [30:0] sc;
  logic [30:0] sq_full;
  logic [SINE_BITS:0] sq;
  logic [SINE_BITS+1:0] w;
  logic [65:0] dsum;
  logic [31:0] d;
  logic [33:0] sfull, steps;

  // ramp decision
  assign diff     = 33'(cmd_r) - 33'(target_r);
  assign span_new = 33'(cmd_r) - 33'(output_r);
  assign mag      = span_r[32] ? 33'(-span_r) : 33'(span_r);
  assign den      = total_r - 1'b1;
  assign rem_ge   = rem_r >= {1'b0, den};

  assign stat.new_ramp   = (diff > EPS_Q16) || (diff < -EPS_Q16);
  assign stat.tiny       = (span_new < EPS_Q16) && (span_new > -EPS_Q16);
  assign stat.active     = active_r;
  assign stat.steps_done = step_r >= total_r;
  assign stat.div_last   = dcnt_r == DLAST;
  assign stat.term_last  = idx_r == 3'(NUM_TERMS - 1);

  // phase to angle magnitude
  assign u_neg = q_r < HALF;
  assign au    = u_neg ? HALF - q_r : q_r - HALF;

  // shared multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_K: begin
        op_a = {1'b0, ramp_rate};
        op_b = mag;
      end
      MUL_PI: begin
        op_a = {1'b0, PI_Q30};
        op_b = 33'(au);
      end
      MUL_AXSQ: begin
        op_a = {1'b0, prod_r[SINE_BITS+31:SINE_BITS]};
        op_b = {1'b0, prod_r[SINE_BITS+31:SINE_BITS]};
      end
      MUL_TX: begin
        op_a = {1'b0, t_r};
        op_b = {1'b0, x2_r};
      end
      MUL_REC: begin
        op_a = {1'b0, prod_r[61:30]};
        op_b = {1'b0, term_recip(idx_r)};
      end
      default: begin
        op_a = mag;
        op_b = 33'(w);
      end
    endcase
  end
  assign prod_nxt = op_a * op_b;

  // reciprocal quotient with one correction step
  assign qe   = prod_r[63:32];
  assign tdiv = term_div(idx_r);
  assign qc   = qe * tdiv;
  assign rmd  = {8'd0, v_r} - qc;
  assign tq   = (rmd >= 40'(tdiv)) ? qe + 1'b1 : qe;

  // clamp, round and sign the sine
  always_comb begin
    if (s_r < 0) begin
      sc = '0;
    end else if (s_r > 34'(ONE_Q30)) begin
      sc = ONE_Q30;
    end else begin
      sc = s_r[30:0];
    end
  end
  assign sq_full = (sc + RND) >> (30 - SINE_BITS);
  assign sq      = (sq_full > 31'(FULL)) ? FULL : sq_full[SINE_BITS:0];
  assign w       = u_neg ? (SINE_BITS + 2)'(FULL) - (SINE_BITS + 2)'(sq)
                         : (SINE_BITS + 2)'(FULL) + (SINE_BITS + 2)'(sq);

  // output scaling
  assign dsum = prod_r + 66'(FULL);
  assign d    = dsum[SINE_BITS+32:SINE_BITS+1];

  // step count saturation
  assign sfull = prod_r[65:32];
  always_comb begin
    if (sfull > LIMIT) begin
      steps = LIMIT;
    end else if (sfull < 34'd2) begin
      steps = 34'd2;
    end else begin
      steps = sfull;
    end
  end

  // ramp state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      start_r  <= '0;
      output_r <= '0;
      span_r   <= '0;
      total_r  <= '0;
      step_r   <= '0;
      active_r <= 1'b0;
    end else begin
      if (cmd.start_ramp) begin
        start_r  <= output_r;
        target_r <= cmd_r;
        step_r   <= '0;
        span_r   <= span_new;
      end
      if (cmd.jump) begin
        output_r <= cmd_r;
        active_r <= 1'b0;
      end
      if (cmd.settle) begin
        output_r <= target_r;
        active_r <= 1'b0;
      end
      if (cmd.set_steps) begin
        total_r  <= steps[STEP_BITS-1:0];
        active_r <= 1'b1;
      end
      if (cmd.ramp_out) begin
        output_r <= span_r[32] ? start_r - d : start_r + d;
        step_r   <= step_r + 1'b1;
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    if (cmd.load_cmd) begin
      cmd_r <= command_speed;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd.div_init) begin
      rem_r  <= {1'b0, step_r};
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? {(rem_r[STEP_BITS-1:0] - den), 1'b0}
                       : {rem_r[STEP_BITS-1:0], 1'b0};
      q_r    <= {q_r[SINE_BITS-1:0], rem_ge};
      dcnt_r <= dcnt_r + 1'b1;
    end
    if (cmd.ax_cap) begin
      ax_r <= prod_r[SINE_BITS+31:SINE_BITS];
    end
    if (cmd.sin_init) begin
      x2_r  <= prod_r[61:30];
      t_r   <= ax_r;
      s_r   <= 34'(ax_r);
      idx_r <= '0;
    end
    if (cmd.v_cap) begin
      v_r <= prod_r[61:30];
    end
    if (cmd.term_upd) begin
      t_r   <= tq;
      s_r   <= idx_r[0] ? s_r + 34'(tq) : s_r - 34'(tq);
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.out_load) begin
      res_speed  <= output_r;
      res_active <= active_r;
    end
  end

  // checks
  a_total_min: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> total_r >= STEP_BITS'(2))
    else $error("active ramp with fewer than two steps");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> step_r <= total_r)
    else $error("step index beyond step count");
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_en && cmd.mul_sel == MUL_PI |-> q_r <= FULL)
    else $error("phase beyond half wave");
  a_term_idx: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.term_upd |-> idx_r < 3'(NUM_TERMS))
    else $error("sine term index out of range");

endmodule

FILE: tb/sv/sine_speed_ramp_generator_tb.sv
// ----------------------------------------------------------------------------
// sine_speed_ramp_generator_tb
// Drives speed commands through the ramp generator with random idle and
// stall cycles, predicts each shaped speed point from an in-bench model of
// the half-sine ramp, and compares every output transfer in order. The ramp
// rate register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module sine_speed_ramp_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEP_BITS = ssrg_pkg::STEP_BITS_DEF;
  localparam int SINE_BITS = ssrg_pkg::SINE_BITS_DEF;
  localparam logic [2:0] ADDR_RAMP_RATE = 3'd0;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_command_speed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_speed;
  logic               out_ramp_active;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [2:0]         cfg_paddr = '0;
  logic [31:0]        cfg_pwdata = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  sine_speed_ramp_generator dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic signed [31:0] speed;
    logic               active;
  } speed_point_t;

  // predictor state
  logic [31:0]        k_rate;
  longint             tgt_speed, ramp_start, ramp_span, cur_speed;
  longint unsigned    ramp_total, ramp_pos;
  bit                 ramping;

  speed_point_t expected_points[$];
  bit      failed = 1'b0;
  int      idle_cycles = 0;

  // sine of a non-negative Q2.30 angle up to pi/2, result in Q30
  function automatic longint sine_q30(longint unsigned ax);
    longint unsigned x2, term;
    longint sum;
    x2 = (ax * ax) >> 30;
    term = ax;
    sum = longint'(ax);
    for (int n = 1; n <= 11; n += 2) begin
      term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
      if (((n / 2) & 1) == 0) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > 64'sd1073741824) sum = 64'sd1073741824;
    return sum;
  endfunction

  function automatic longint ramp_speed_at();
    longint unsigned den, full, q, au, ax, sq, w, mag, d;
    longint u;
    den = ramp_total > 1 ? ramp_total - 1 : 1;
    full = 64'd1 << SINE_BITS;
    q = (ramp_pos << SINE_BITS) / den;
    if (q > full) q = full;
    u = longint'(q) - longint'(full >> 1);
    au = u < 0 ? -u : u;
    ax = (64'd3373259426 * au) >> SINE_BITS;
    sq = (longint'(sine_q30(ax)) + (64'd1 << (29 - SINE_BITS))) >> (30 - SINE_BITS);
    if (sq > full) sq = full;
    w = u < 0 ? full - sq : full + sq;
    mag = ramp_span < 0 ? -ramp_span : ramp_span;
    d = (mag * w + full) >> (SINE_BITS + 1);
    return ramp_span < 0 ? ramp_start - longint'(d) : ramp_start + longint'(d);
  endfunction

  // advance the ramp model by one tick and return the shaped point
  function automatic speed_point_t next_speed_point(logic signed [31:0] cmd);
    longint diff;
    longint unsigned mag, steps;
    speed_point_t p;
    diff = longint'(cmd) - tgt_speed;
    if (diff > 66 || diff < -66) begin
      ramp_start = cur_speed;
      tgt_speed = cmd;
      ramp_pos = 0;
      ramp_span = tgt_speed - ramp_start;
      if (ramp_span < 66 && ramp_span > -66) begin
        cur_speed = tgt_speed;
        ramping = 1'b0;
      end else begin
        mag = ramp_span < 0 ? -ramp_span : ramp_span;
        steps = (longint'(k_rate) * mag) >> 32;
        if (steps > (64'd1 << STEP_BITS) - 1) steps = (64'd1 << STEP_BITS) - 1;
        if (steps < 2) steps = 2;
        ramp_total = steps;
        ramping = 1'b1;
      end
    end
    if (ramping) begin
      if (ramp_pos >= ramp_total) begin
        cur_speed = tgt_speed;
        ramping = 1'b0;
      end else begin
        cur_speed = ramp_speed_at();
        ramp_pos++;
      end
    end
    p.speed = cur_speed[31:0];
    p.active = ramping;
    return p;
  endfunction

  // send one command transfer after a random gap; valid drops only for a gap
  task automatic send_command(logic signed [31:0] cmd, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command_speed <= cmd;
    do @(posedge clk); while (!in_ready);
    expected_points.push_back(next_speed_point(cmd));
  endtask

  // write the ramp rate register once every expected point has come back
  task automatic write_k_rate(logic [31:0] value);
    in_valid <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_RAMP_RATE;
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    k_rate = value;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic test_directed_extremes();
    send_command(32'sh7fffffff);
    send_command(32'sh80000000);
    send_command(32'sh80000000);
    send_command(32'sh80000000 + 32'sd40);
    send_command(32'sd0);
    send_command(32'sd66);
    send_command(32'sd133);
    send_command(32'sd100);
    send_command(32'sd0);
    send_command(32'sd0);
    send_command(32'sh0001_0000);
    repeat (8) send_command(32'sh0001_0000);
  endtask

  task automatic test_zero_rate();
    write_k_rate(32'd0);
    send_command(32'sh0010_0000);
    repeat (3) send_command(32'sh0010_0000);
    send_command(-32'sh0010_0000);
    repeat (3) send_command(-32'sh0010_0000);
  endtask

  task automatic test_max_rate();
    write_k_rate(32'hffff_ffff);
    send_command(32'sd200);
    repeat (10) send_command(32'sd200);
    send_command(32'sh7fff_0000);
    repeat (6) send_command(32'sh7fff_0000);
  endtask

  // random commands: mostly held targets that let ramps play out
  task automatic test_random_ramps(int count, logic [31:0] rate);
    logic signed [31:0] cmd;
    int hold;
    write_k_rate(rate);
    cmd = 0;
    while (count > 0) begin
      case ($urandom_range(0, 3))
        0: cmd = $urandom();
        1: cmd = $signed($urandom_range(0, 32'h000f_ffff)) - 32'sh0008_0000;
        2: cmd = cmd + $signed($urandom_range(0, 200)) - 32'sd100;
        default: cmd = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
      endcase
      hold = $urandom_range(1, 30);
      for (int i = 0; i < hold && count > 0; i++) begin
        send_command(cmd, ($urandom_range(0, 4) != 0));
        count--;
      end
    end
  endtask

  // result side: random stalls, compare in order
  initial begin
    speed_point_t exp_pt;
    int stall;
    @(posedge rst_n);
    forever begin
      stall = $urandom_range(0, 17);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_points.size() == 0) begin
        $error("unexpected output transfer: speed %0d active %0d", out_speed, out_ramp_active);
        failed = 1'b1;
      end else begin
        exp_pt = expected_points.pop_front();
        if (out_speed !== exp_pt.speed) begin
          $error("out_speed expected %0d actual %0d", exp_pt.speed, out_speed);
          failed = 1'b1;
        end
        if (out_ramp_active !== exp_pt.active) begin
          $error("out_ramp_active expected %0d actual %0d", exp_pt.active, out_ramp_active);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog: count cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    k_rate = ssrg_pkg::K_RESET;
    tgt_speed = 0;
    ramp_start = 0;
    ramp_span = 0;
    cur_speed = 0;
    ramp_total = 0;
    ramp_pos = 0;
    ramping = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_extremes();
    test_zero_rate();
    test_max_rate();
    test_random_ramps(700, ssrg_pkg::K_RESET);
    test_random_ramps(600, 32'd65536);
    test_random_ramps(600, $urandom());
    in_valid <= 1'b0;
    wait (expected_points.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
